// File: hdl/sps_pkg.sv
// Shared types and constants for the SHA-1 prefix search step block.
`default_nettype none
package sps_pkg;
	localparam int CandLen = 55;
	localparam int CandBits = CandLen * 8;
	localparam logic [7:0] DigitLo = 8'd33;
	localparam logic [7:0] DigitHi = 8'd127;
	localparam int QueueDepth = 2;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_STEP = 1'b1
	} opcode_t;

	typedef enum logic [2:0] {
		REG_MID_A = 3'd0,
		REG_MID_B = 3'd1,
		REG_MID_C = 3'd2,
		REG_MID_D = 3'd3,
		REG_MID_E = 3'd4
	} reg_idx_t;

	// One queued job handed from the front to the back.
	typedef struct packed {
		logic step;
		logic [CandBits-1:0] cand;
	} job_t;

	function automatic logic [CandBits-1:0] cand_reset();
		logic [CandBits-1:0] r;
		for (int i = 0; i < CandLen; i++) r[8*i +: 8] = DigitLo;
		return r;
	endfunction

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction
endpackage
`default_nettype wire

// File: hdl/sps_front.sv
// Front part: holds the candidate, loads or advances it, and queues jobs.
`default_nettype none
module sps_front
	import sps_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_go,
	input wire logic in_step,
	input wire logic [CandBits-1:0] in_seed,
	output job_t job,
	output logic ctr_busy
);
	logic [CandBits-1:0] cand_q;
	logic [CandBits-1:0] next_cand;
	logic carry;

	// Odometer advance: 127 wraps and carries; the first other byte adds 1 mod 256.
	always_comb begin
		next_cand = cand_q;
		carry = 1'b1;
		for (int i = 0; i < CandLen; i++) begin
			if (carry) begin
				if (cand_q[8*i +: 8] == DigitHi) begin
					next_cand[8*i +: 8] = DigitLo;
				end else begin
					next_cand[8*i +: 8] = cand_q[8*i +: 8] + 8'd1;
					carry = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= cand_reset();
		end else if (in_go) begin
			cand_q <= in_step ? next_cand : in_seed;
		end
	end

	assign job.step = in_step;
	assign job.cand = in_step ? next_cand : in_seed;
	assign ctr_busy = 1'b0;
endmodule
`default_nettype wire

// File: hdl/sps_queue.sv
// Short job queue between the front and the back.
`default_nettype none
module sps_queue
	import sps_pkg::*;
#(
	parameter int Depth = QueueDepth
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input job_t push_data,
	input wire logic pop,
	output job_t head,
	output logic not_empty,
	output logic full
);
	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	job_t slot_q [Depth];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0] cnt_q;

	assign not_empty = cnt_q != '0;
	assign full = cnt_q == (AW+1)'(Depth);
	assign head = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) full |-> !push)
		else $error("queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n) !not_empty |-> !pop)
		else $error("queue underflow");
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= (AW+1)'(Depth))
		else $error("queue count out of range");
endmodule
`default_nettype wire

// File: hdl/sps_back.sv
// Back part: one SHA-1 round per cycle, hit test and output register.
`default_nettype none
module sps_back
	import sps_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input job_t job,
	input wire logic job_valid,
	output logic job_pop,
	input wire logic [31:0] mid_a,
	input wire logic [31:0] mid_b,
	input wire logic [31:0] mid_c,
	input wire logic [31:0] mid_d,
	input wire logic [31:0] mid_e,
	output logic out_valid,
	input wire logic out_stall,
	output logic out_hit,
	output logic [CandBits-1:0] out_cand
);
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t state_q;
	logic [6:0] rnd_q;
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [31:0] w_q [16];
	logic [CandBits-1:0] cand_q;
	logic valid_q, hit_q;
	logic [31:0] f, k, t, wnew, wcur;
	logic [31:0] h0, h1;
	logic out_free;
	logic out_load;
	logic [511:0] blk;

	assign out_free = !valid_q || !out_stall;

	always_comb begin
		for (int i = 0; i < CandLen; i++) blk[511 - 8*i -: 8] = job.cand[8*i +: 8];
		blk[511 - 8*CandLen -: 8] = 8'h80;
		blk[63:16] = '0;
		blk[15:8] = 8'h03;
		blk[7:0] = 8'hb8;
	end

	assign job_pop = job_valid && (state_q == ST_IDLE) && (job.step || out_free);

	// A new result enters the output register on a load pop or when a step finishes.
	assign out_load = (job_pop && !job.step) || (state_q == ST_DONE && out_free);

	always_comb begin
		if (rnd_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q); k = 32'h5A827999;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q; k = 32'h6ED9EBA1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q); k = 32'h8F1BBCDC;
		end else begin
			f = b_q ^ c_q ^ d_q; k = 32'hCA62C1D6;
		end
		wnew = rotl(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0], 1);
		wcur = (rnd_q < 7'd16) ? w_q[0] : wnew;
		t = rotl(a_q, 5) + f + e_q + k + wcur;
		h0 = mid_a + a_q;
		h1 = mid_b + b_q;
	end

	always_ff @(posedge clk) begin
		if (job_pop && job.step) begin
			for (int i = 0; i < 16; i++) w_q[i] <= blk[511 - 32*i -: 32];
			a_q <= mid_a; b_q <= mid_b; c_q <= mid_c; d_q <= mid_d; e_q <= mid_e;
			cand_q <= job.cand;
		end else if (state_q == ST_RUN) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wcur;
			a_q <= t; b_q <= a_q; c_q <= rotl(b_q, 30); d_q <= c_q; e_q <= d_q;
		end
		if (job_pop && !job.step) begin
			out_cand <= job.cand;
			hit_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_cand <= cand_q;
			hit_q <= (h0 == 32'd0) && (h1[15:0] == 16'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				valid_q <= 1'b1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (job_pop && job.step) begin
						state_q <= ST_RUN;
						rnd_q <= '0;
					end
				end
				ST_RUN: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == 7'd79) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = valid_q;
	assign out_hit = hit_q;

	assert property (@(posedge clk) disable iff (!arst_n) state_q == ST_RUN |-> rnd_q < 7'd80)
		else $error("round counter overran");
	assert property (@(posedge clk) disable iff (!arst_n)
		$past(state_q) == ST_DONE && state_q == ST_IDLE |-> valid_q)
		else $error("finished step produced no result");
	assert property (@(posedge clk) disable iff (!arst_n) valid_q && out_stall |=> valid_q)
		else $error("result dropped while stalled");
endmodule
`default_nettype wire

// File: hdl/sha1_prefix_search_step.sv
// Top level of the SHA-1 prefix search step block.
// This block searches for a SHA-1 second message block whose compression, started from the
// midstate in the configuration registers, gives a zero first word and a second word with
// zero low 16 bits. A load transaction replaces the 55-byte candidate and returns it with hit
// low. A step transaction advances the candidate as an odometer over the digits 33..127 and
// returns the new candidate and the hit flag, computed by the single SHA-1 round unit that
// runs one round per cycle. The front advances the candidate at once and queues the job, so
// input is taken while the round unit works, until the two-entry queue is full.
// Configuration must be written only while the block is idle.
`default_nettype none
module sha1_prefix_search_step
	import sps_pkg::*;
#(
	parameter int Depth = QueueDepth
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [31:0] cfg_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic opcode,
	input wire logic [63:0] seed_bytes_0_7,
	input wire logic [63:0] seed_bytes_8_15,
	input wire logic [63:0] seed_bytes_16_23,
	input wire logic [63:0] seed_bytes_24_31,
	input wire logic [63:0] seed_bytes_32_39,
	input wire logic [63:0] seed_bytes_40_47,
	input wire logic [55:0] seed_bytes_48_54,
	output logic out_valid,
	input wire logic out_stall,
	output logic hit,
	output logic [63:0] cand_bytes_0_7,
	output logic [63:0] cand_bytes_8_15,
	output logic [63:0] cand_bytes_16_23,
	output logic [63:0] cand_bytes_24_31,
	output logic [63:0] cand_bytes_32_39,
	output logic [63:0] cand_bytes_40_47,
	output logic [55:0] cand_bytes_48_54
);
	// Midstate registers, reset to the standard SHA-1 initial values.
	logic [31:0] mid_a_q, mid_b_q, mid_c_q, mid_d_q, mid_e_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_a_q <= 32'h67452301;
			mid_b_q <= 32'hEFCDAB89;
			mid_c_q <= 32'h98BADCFE;
			mid_d_q <= 32'h10325476;
			mid_e_q <= 32'hC3D2E1F0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_MID_A: mid_a_q <= cfg_data;
				REG_MID_B: mid_b_q <= cfg_data;
				REG_MID_C: mid_c_q <= cfg_data;
				REG_MID_D: mid_d_q <= cfg_data;
				REG_MID_E: mid_e_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic q_full, q_ne, q_pop, in_go, front_busy;
	job_t fjob, qhead;
	logic [CandBits-1:0] seed, ocand;

	assign seed = {seed_bytes_48_54, seed_bytes_40_47, seed_bytes_32_39, seed_bytes_24_31,
		seed_bytes_16_23, seed_bytes_8_15, seed_bytes_0_7};
	// The front never holds off on its own; only a full queue stalls input.
	assign in_stall = q_full || front_busy;
	assign in_go = in_valid && !in_stall;

	sps_front u_front (
		.clk(clk), .arst_n(arst_n), .in_go(in_go), .in_step(opcode == OP_STEP),
		.in_seed(seed), .job(fjob), .ctr_busy(front_busy)
	);

	sps_queue #(.Depth(Depth)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(in_go), .push_data(fjob), .pop(q_pop),
		.head(qhead), .not_empty(q_ne), .full(q_full)
	);

	sps_back u_back (
		.clk(clk), .arst_n(arst_n), .job(qhead), .job_valid(q_ne), .job_pop(q_pop),
		.mid_a(mid_a_q), .mid_b(mid_b_q), .mid_c(mid_c_q), .mid_d(mid_d_q), .mid_e(mid_e_q),
		.out_valid(out_valid), .out_stall(out_stall), .out_hit(hit), .out_cand(ocand)
	);

	assign {cand_bytes_48_54, cand_bytes_40_47, cand_bytes_32_39, cand_bytes_24_31,
		cand_bytes_16_23, cand_bytes_8_15, cand_bytes_0_7} = ocand;

	assert property (@(posedge clk) disable iff (!arst_n) in_go |-> !q_full)
		else $error("accepted input into a full queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hit) && $stable(ocand))
		else $error("stalled result changed");
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_ne)
		else $error("back popped an empty queue");
endmodule
`default_nettype wire
